// ----- design/rpfa_pkg.sv -----
`timescale 1ns / 1ps

package rpfa_pkg;

  localparam int NUM_FRAMES  = 4096;
  localparam int COUNT_W     = 16;
  localparam int FRAME_W     = $clog2(NUM_FRAMES);
  localparam int DEPTH_W     = FRAME_W + 1;
  localparam int TOTAL_W     = 13;
  localparam int RESERVED_W  = 12;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 3;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;

  localparam logic [TOTAL_W-1:0]    TOTAL_RESET    = TOTAL_W'(4096);
  localparam logic [RESERVED_W-1:0] RESERVED_RESET = RESERVED_W'(8);
  localparam logic [COUNT_W-1:0]    COUNT_MAX      = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_ADDREF = 2'd2;
  localparam logic [OP_W-1:0] OP_DROP   = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVER  = 3'd4;

  // register indexes
  localparam logic REG_TOTAL_FRAMES    = 1'b0;
  localparam logic REG_RESERVED_FRAMES = 1'b1;

  typedef struct packed {
    logic clear;
    logic accept;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_busy;
  } dp_status_t;

  typedef struct packed {
    logic                  wr;
    logic                  idx;
    logic [APB_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ----- design/rpfa_ram.sv -----
`timescale 1ns / 1ps

module rpfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/rpfa_ctrl.sv -----
`timescale 1ns / 1ps

module rpfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpfa_pkg::dp_status_t dp_status,
  output rpfa_pkg::ctrl_cmd_t  cmd
);

  import rpfa_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      in_ready <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (dp_status.clear_last) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_EXEC;
            in_ready <= 1'b0;
          end
        end
        S_EXEC: begin
          // hold while the previous result still waits in the output register
          if (!dp_status.out_busy) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end
        end
        default: begin
          state    <= S_CLEAR;
          in_ready <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd.clear   = (state == S_CLEAR);
    cmd.accept  = in_valid && in_ready;
    cmd.execute = (state == S_EXEC) && !dp_status.out_busy;
  end

endmodule

// ----- design/rpfa_dp.sv -----
`timescale 1ns / 1ps

module rpfa_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  rpfa_pkg::ctrl_cmd_t                 cmd,
  output rpfa_pkg::dp_status_t                dp_status,
  input  rpfa_pkg::cfg_wr_t                   cfg_wr,
  input  logic                                cfg_rd_idx,
  output logic [rpfa_pkg::APB_DATA_W-1:0]     cfg_rdata,
  input  logic [rpfa_pkg::OP_W-1:0]           operation,
  input  logic [rpfa_pkg::FRAME_W-1:0]        frame_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rpfa_pkg::FRAME_W-1:0]        frame_out,
  output logic [rpfa_pkg::COUNT_W-1:0]        ref_count,
  output logic [rpfa_pkg::STATUS_W-1:0]       status
);

  import rpfa_pkg::*;

  logic [TOTAL_W-1:0]    total_frames;
  logic [RESERVED_W-1:0] reserved_frames;
  logic [DEPTH_W-1:0]    stack_depth;
  logic [DEPTH_W-1:0]    stack_depth_next;
  logic [DEPTH_W-1:0]    fresh_handed_out;
  logic [DEPTH_W-1:0]    fresh_handed_out_next;
  logic [FRAME_W-1:0]    clr_addr;
  logic [OP_W-1:0]       op_q;
  logic [FRAME_W-1:0]    frame_q;

  logic                  cnt_we;
  logic [FRAME_W-1:0]    cnt_waddr;
  logic [COUNT_W-1:0]    cnt_wdata;
  logic [COUNT_W-1:0]    cnt_rdata;
  logic                  exe_cnt_we;
  logic [FRAME_W-1:0]    exe_cnt_waddr;
  logic [COUNT_W-1:0]    exe_cnt_wdata;
  logic                  stk_we;
  logic [FRAME_W-1:0]    stk_rdata;
  logic [FRAME_W-1:0]    stk_raddr;

  logic [TOTAL_W-1:0]    limit;
  logic [TOTAL_W-1:0]    resv_ext;
  logic                  fresh_ok;
  logic                  frame_ok;
  logic [TOTAL_W-1:0]    fresh_frame;
  logic [FRAME_W-1:0]    res_frame;
  logic [COUNT_W-1:0]    res_count;
  logic [STATUS_W-1:0]   res_status;

  assign dp_status.clear_last = cmd.clear && (clr_addr == '1);
  assign dp_status.out_busy   = out_valid && !out_ready;

  assign cfg_rdata = (cfg_rd_idx == REG_TOTAL_FRAMES) ?
                     APB_DATA_W'(total_frames) : APB_DATA_W'(reserved_frames);

  assign stk_raddr = FRAME_W'(stack_depth - DEPTH_W'(1));

  rpfa_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_FRAMES)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cmd.accept),
    .raddr (frame_index),
    .rdata (cnt_rdata)
  );

  rpfa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (NUM_FRAMES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stack_depth[FRAME_W-1:0]),
    .wdata (frame_q),
    .re    (cmd.accept),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // clear pass owns the count table write port until it finishes
  always_comb begin
    if (cmd.clear) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_addr;
      cnt_wdata = '0;
    end else begin
      cnt_we    = exe_cnt_we;
      cnt_waddr = exe_cnt_waddr;
      cnt_wdata = exe_cnt_wdata;
    end
  end

  always_comb begin
    limit       = (total_frames > TOTAL_W'(NUM_FRAMES)) ? TOTAL_W'(NUM_FRAMES) : total_frames;
    resv_ext    = TOTAL_W'(reserved_frames);
    fresh_ok    = (limit > resv_ext) &&
                  (TOTAL_W'(fresh_handed_out) < (limit - resv_ext));
    fresh_frame = limit - TOTAL_W'(1) - TOTAL_W'(fresh_handed_out);
    frame_ok    = (TOTAL_W'(frame_q) >= resv_ext) && (TOTAL_W'(frame_q) < limit);

    res_frame             = frame_q;
    res_count             = '0;
    res_status            = ST_OK;
    exe_cnt_we            = 1'b0;
    exe_cnt_waddr         = frame_q;
    exe_cnt_wdata         = '0;
    stk_we                = 1'b0;
    stack_depth_next      = stack_depth;
    fresh_handed_out_next = fresh_handed_out;

    if (op_q == OP_ALLOC) begin
      if (stack_depth != '0) begin
        stack_depth_next = stack_depth - DEPTH_W'(1);
        res_frame        = stk_rdata;
        res_count        = COUNT_W'(1);
        exe_cnt_we       = 1'b1;
        exe_cnt_waddr    = stk_rdata;
        exe_cnt_wdata    = COUNT_W'(1);
      end else if (fresh_ok) begin
        fresh_handed_out_next = fresh_handed_out + DEPTH_W'(1);
        res_frame             = fresh_frame[FRAME_W-1:0];
        res_count             = COUNT_W'(1);
        exe_cnt_we            = 1'b1;
        exe_cnt_waddr         = fresh_frame[FRAME_W-1:0];
        exe_cnt_wdata         = COUNT_W'(1);
      end else begin
        res_frame  = '0;
        res_status = ST_OOM;
      end
    end else if (!frame_ok) begin
      res_status = ST_BAD;
    end else if (op_q == OP_ADDREF) begin
      if (cnt_rdata == COUNT_MAX) begin
        res_count  = COUNT_MAX;
        res_status = ST_OVER;
      end else begin
        res_count     = cnt_rdata + COUNT_W'(1);
        exe_cnt_we    = 1'b1;
        exe_cnt_wdata = cnt_rdata + COUNT_W'(1);
      end
    end else begin
      if (cnt_rdata == '0) begin
        res_status = ST_UNDER;
      end else begin
        res_count     = cnt_rdata - COUNT_W'(1);
        exe_cnt_we    = 1'b1;
        exe_cnt_wdata = cnt_rdata - COUNT_W'(1);
        // on a free, push the frame back once its last reference is gone and the stack has room
        if (op_q == OP_FREE && cnt_rdata == COUNT_W'(1) &&
            stack_depth < DEPTH_W'(NUM_FRAMES)) begin
          stk_we           = 1'b1;
          stack_depth_next = stack_depth + DEPTH_W'(1);
        end
      end
    end

    if (!cmd.execute) begin
      exe_cnt_we = 1'b0;
      stk_we     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_frames     <= TOTAL_RESET;
      reserved_frames  <= RESERVED_RESET;
      stack_depth      <= '0;
      fresh_handed_out <= '0;
      clr_addr         <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_wr.wr) begin
        if (cfg_wr.idx == REG_TOTAL_FRAMES) begin
          total_frames <= cfg_wr.data[TOTAL_W-1:0];
        end else begin
          reserved_frames <= cfg_wr.data[RESERVED_W-1:0];
        end
      end
      if (cmd.clear) begin
        clr_addr <= clr_addr + FRAME_W'(1);
      end
      if (cmd.execute) begin
        stack_depth      <= stack_depth_next;
        fresh_handed_out <= fresh_handed_out_next;
        out_valid        <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q    <= operation;
      frame_q <= frame_index;
    end
    if (cmd.execute) begin
      frame_out <= res_frame;
      ref_count <= res_count;
      status    <= res_status;
    end
  end

endmodule

// ----- design/refcounted_page_frame_allocator.sv -----
`timescale 1ns / 1ps

// Page-frame allocator with a saturating reference count per frame. Each
// operation (allocate, free, add reference, drop reference) gives exactly one
// result. The accept cycle issues reads of the count table and free stack
// RAMs, and the execute state does the read-modify-write and loads the output
// register; it is a separate state because the RAM read is registered. The
// output register lets the next item enter while a result waits; an item
// holds in its execute cycle until the earlier result is taken. After reset
// the count table is cleared in a pass over all 4096 entries during which
// in_ready stays low; configuration writes are taken at all times.
module refcounted_page_frame_allocator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rpfa_pkg::OP_W-1:0]           operation,
  input  logic [rpfa_pkg::FRAME_W-1:0]        frame_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [rpfa_pkg::FRAME_W-1:0]        frame_out,
  output logic [rpfa_pkg::COUNT_W-1:0]        ref_count,
  output logic [rpfa_pkg::STATUS_W-1:0]       status,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rpfa_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [rpfa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [rpfa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  import rpfa_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;
  cfg_wr_t    cfg_wr;

  assign pready      = 1'b1;
  assign cfg_wr.wr   = psel && penable && pwrite && pready;
  assign cfg_wr.idx  = paddr[2];
  assign cfg_wr.data = pwdata;

  rpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .dp_status (dp_status),
    .cmd       (cmd)
  );

  rpfa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .dp_status   (dp_status),
    .cfg_wr      (cfg_wr),
    .cfg_rd_idx  (paddr[2]),
    .cfg_rdata   (prdata),
    .operation   (operation),
    .frame_index (frame_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_out   (frame_out),
    .ref_count   (ref_count),
    .status      (status)
  );

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in execute");

  a_result_follows_execute: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without an item in execute");

  a_bad_frame_zero_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BAD || status == ST_UNDER || status == ST_OOM)
      |-> ref_count == '0)
    else $error("rejected operation reported a nonzero count");

  a_oom_frame_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OOM |-> frame_out == '0)
    else $error("out-of-memory result carries a frame");

endmodule
